// File: rtl/text_line_splitter_unit_assert.svh
// Assertion macros for the text line splitter.
// Included by the top level; no other dependencies.
`ifndef TEXT_LINE_SPLITTER_UNIT_ASSERT_SVH
`define TEXT_LINE_SPLITTER_UNIT_ASSERT_SVH

// Check an implication in the same cycle.
`define TLS_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("text line splitter: check failed");

// Check an implication in the next cycle.
`define TLS_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("text line splitter: check failed");

`endif

// File: rtl/tls_pkg.sv
// Shared types, codes and helpers for the text line splitter.
// No dependencies.
`default_nettype none

package tls_pkg;

   localparam int COUNT_WIDTH    = 32;
   localparam int LINE_LEN_WIDTH = 16;

   localparam logic [LINE_LEN_WIDTH-1:0] LINE_LEN_MAX = {LINE_LEN_WIDTH{1'b1}};

   localparam logic [7:0] BYTE_CR  = 8'd13;
   localparam logic [7:0] BYTE_LF  = 8'd10;
   localparam logic [7:0] BYTE_NUL = 8'd0;

   localparam logic [1:0] MODE_DATA  = 2'd0;
   localparam logic [1:0] MODE_PLAIN = 2'd1;
   localparam logic [1:0] MODE_SKIP  = 2'd2;
   localparam logic [1:0] MODE_EOS   = 2'd3;

   localparam logic [2:0] KIND_LINE  = 3'd0;
   localparam logic [2:0] KIND_EOL   = 3'd1;
   localparam logic [2:0] KIND_PLAIN = 3'd2;
   localparam logic [2:0] KIND_SKIP  = 3'd3;
   localparam logic [2:0] KIND_ANOM  = 3'd4;

   localparam logic [1:0] ANOM_NONE = 2'd0;
   localparam logic [1:0] ANOM_LF   = 2'd1;
   localparam logic [1:0] ANOM_CR   = 2'd2;
   localparam logic [1:0] ANOM_NUL  = 2'd3;

   localparam logic [1:0] CSR_CR_IS_EOL  = 2'd0;
   localparam logic [1:0] CSR_LF_IS_EOL  = 2'd1;
   localparam logic [1:0] CSR_NUL_REPORT = 2'd2;

   typedef struct packed {
      logic [1:0]  mode;
      logic [7:0]  data_byte;
      logic [31:0] length_value;
   } req_beat_type;

   typedef struct packed {
      logic [2:0]  kind;
      logic [7:0]  out_byte;
      logic [15:0] line_length;
      logic [1:0]  anomaly_code;
      logic        last_of_run;
   } rsp_beat_type;

   function automatic rsp_beat_type make_rsp(
      input logic [2:0]                kind,
      input logic [7:0]                byte_val,
      input logic [LINE_LEN_WIDTH-1:0] len,
      input logic [1:0]                code
   );
      rsp_beat_type r;
      r.kind         = kind;
      r.out_byte     = byte_val;
      r.line_length  = 16'(len);
      r.anomaly_code = code;
      r.last_of_run  = 1'b0;
      return r;
   endfunction

endpackage

`default_nettype wire

// File: rtl/text_line_splitter_unit.sv
// Top level of the text line splitter: framing logic and result buffer.
// Depends on tls_pkg and text_line_splitter_unit_assert.svh.
`default_nettype none
// Latency: the first result of an item is on rsp_* the cycle after the item is accepted.
// Throughput: one item per cycle while each item yields at most one result and rsp_stall
//   is low; an item with n results (n up to 3) holds off the next item until its last
//   beat leaves, set by the single result port draining one beat per cycle unless stalled.
// Reset: synchronous, active high; clears framing state, counts and the result buffer,
//   and loads the register defaults (CR and LF end lines, NUL flagging off).

`include "text_line_splitter_unit_assert.svh"

module text_line_splitter_unit (
   input  wire                  clock,
   input  wire                  reset,
   input  wire                  req_valid,
   output logic                 req_stall,
   input  tls_pkg::req_beat_type req_payload,
   output logic                 rsp_valid,
   input  wire                  rsp_stall,
   output tls_pkg::rsp_beat_type rsp_payload,
   input  wire                  csr_we,
   input  wire  [1:0]           csr_index,
   input  wire  [0:0]           csr_wdata
);

   localparam int CW = tls_pkg::COUNT_WIDTH;
   localparam int LW = tls_pkg::LINE_LEN_WIDTH;

   // Configuration registers.
   logic cr_is_eol_ff, cr_is_eol_in;
   logic lf_is_eol_ff, lf_is_eol_in;
   logic nul_report_ff, nul_report_in;

   // Framing state.
   logic          last_was_cr_ff, last_was_cr_in;
   logic          cr_held_ff, cr_held_in;
   logic          nul_active_ff, nul_active_in;
   logic [LW-1:0] line_len_ff, line_len_in;
   logic [CW-1:0] plain_rem_ff, plain_rem_in;
   logic [CW-1:0] skip_rem_ff, skip_rem_in;
   logic [CW-1:0] skip_pend_ff, skip_pend_in;

   // Result buffer: up to three beats of one item, slot 0 faces the port.
   tls_pkg::rsp_beat_type slot_ff [3];
   tls_pkg::rsp_beat_type slot_in [3];
   logic [1:0]            count_ff, count_in;

   // Results of the item on the input port, worked out in this cycle.
   tls_pkg::rsp_beat_type res_v [3];
   logic [1:0]            res_cnt;

   logic req_accept;
   logic rsp_pop;

   // Valid comes from the buffer alone; take a new beat when the buffer is empty or
   // empties this cycle, so a single-result stream moves every cycle unless stalled.
   assign rsp_valid   = (count_ff != 2'd0);
   assign rsp_payload = slot_ff[0];
   assign rsp_pop     = rsp_valid && !rsp_stall;
   assign req_stall   = (count_ff > 2'd1) || ((count_ff == 2'd1) && rsp_stall);
   assign req_accept  = req_valid && !req_stall;

   // Framing: one pass over the accepted beat.
   always_comb begin
      logic          lwc;
      logic          crh;
      logic          nact;
      logic [LW-1:0] len;
      logic [CW-1:0] plain;
      logic [CW-1:0] skr;
      logic [CW-1:0] pend;
      logic [CW-1:0] cnt_val;
      logic [7:0]    b;
      logic          run_data;
      logic          eaten;
      logic          done;
      logic [1:0]    n;

      lwc     = last_was_cr_ff;
      crh     = cr_held_ff;
      nact    = nul_active_ff;
      len     = line_len_ff;
      plain   = plain_rem_ff;
      skr     = skip_rem_ff;
      pend    = skip_pend_ff;
      cnt_val = CW'(req_payload.length_value);
      n       = 2'd0;
      done    = 1'b0;
      eaten   = 1'b0;
      for (int i = 0; i < 3; i++) begin
         res_v[i] = '0;
      end

      // End of stream closes a partial line as if an LF had arrived.
      run_data = 1'b0;
      b        = req_payload.data_byte;
      unique case (req_payload.mode)
         tls_pkg::MODE_DATA: begin
            run_data = 1'b1;
         end
         tls_pkg::MODE_PLAIN: begin
            plain = cnt_val;
         end
         tls_pkg::MODE_SKIP: begin
            if (lwc) begin
               pend = cnt_val;
            end else begin
               pend = '0;
               skr  = cnt_val;
            end
         end
         tls_pkg::MODE_EOS: begin
            run_data = (len != '0);
            b        = tls_pkg::BYTE_LF;
         end
         default: begin
            run_data = 1'b0;
         end
      endcase

      if (run_data) begin
         // Absorb the LF of a CRLF when CR alone ends lines.
         if (cr_is_eol_ff && lwc && (b == tls_pkg::BYTE_LF)) begin
            if (crh) begin
               res_v[n] = tls_pkg::make_rsp(tls_pkg::KIND_LINE, tls_pkg::BYTE_CR, '0,
                                            tls_pkg::ANOM_NONE);
               n   = n + 2'd1;
               crh = 1'b0;
            end
            lwc   = 1'b0;
            eaten = 1'b1;
         end

         if (plain != '0) begin
            // Plain pass-through.
            if (!eaten) begin
               if (crh) begin
                  res_v[n] = tls_pkg::make_rsp(tls_pkg::KIND_LINE, tls_pkg::BYTE_CR, '0,
                                               tls_pkg::ANOM_NONE);
                  n   = n + 2'd1;
                  crh = 1'b0;
               end
               res_v[n] = tls_pkg::make_rsp(tls_pkg::KIND_PLAIN, b, '0,
                                            tls_pkg::ANOM_NONE);
               n     = n + 2'd1;
               plain = plain - CW'(1);
               lwc   = 1'b0;
            end
            done = 1'b1;
         end else begin
            // Arm a deferred skip now that the CRLF check is past.
            if (pend != '0) begin
               skr  = pend;
               pend = '0;
            end
            if (eaten) begin
               done = 1'b1;
            end else if (skr != '0) begin
               res_v[n] = tls_pkg::make_rsp(tls_pkg::KIND_SKIP, b, '0,
                                            tls_pkg::ANOM_NONE);
               n    = n + 2'd1;
               skr  = skr - CW'(1);
               done = 1'b1;
            end
         end

         if (!done) begin
            priority if (b == tls_pkg::BYTE_CR) begin
               if (crh) begin
                  res_v[n] = tls_pkg::make_rsp(tls_pkg::KIND_LINE, tls_pkg::BYTE_CR, '0,
                                               tls_pkg::ANOM_NONE);
                  n   = n + 2'd1;
                  crh = 1'b0;
               end
               if (cr_is_eol_ff) begin
                  res_v[n] = tls_pkg::make_rsp(tls_pkg::KIND_EOL, 8'd0, len,
                                               tls_pkg::ANOM_NONE);
                  n    = n + 2'd1;
                  len  = '0;
                  lwc  = 1'b1;
                  done = 1'b1;
               end else begin
                  if (len != tls_pkg::LINE_LEN_MAX) begin
                     len = len + LW'(1);
                  end
                  crh = 1'b1;
               end
            end else if (b == tls_pkg::BYTE_LF) begin
               if (lwc) begin
                  // Drop a held CR from the line; a saturated count stays.
                  if (crh) begin
                     if ((len != '0) && (len != tls_pkg::LINE_LEN_MAX)) begin
                        len = len - LW'(1);
                     end
                     crh = 1'b0;
                  end
                  res_v[n] = tls_pkg::make_rsp(tls_pkg::KIND_EOL, 8'd0, len,
                                               tls_pkg::ANOM_NONE);
                  n    = n + 2'd1;
                  len  = '0;
                  lwc  = 1'b0;
                  done = 1'b1;
               end else if (lf_is_eol_ff) begin
                  res_v[n] = tls_pkg::make_rsp(tls_pkg::KIND_EOL, 8'd0, len,
                                               tls_pkg::ANOM_NONE);
                  n    = n + 2'd1;
                  len  = '0;
                  lwc  = 1'b0;
                  done = 1'b1;
               end else begin
                  res_v[n] = tls_pkg::make_rsp(tls_pkg::KIND_ANOM, 8'd0, '0,
                                               tls_pkg::ANOM_LF);
                  n        = n + 2'd1;
                  res_v[n] = tls_pkg::make_rsp(tls_pkg::KIND_LINE, b, '0,
                                               tls_pkg::ANOM_NONE);
                  n        = n + 2'd1;
                  if (len != tls_pkg::LINE_LEN_MAX) begin
                     len = len + LW'(1);
                  end
               end
            end else if ((b == tls_pkg::BYTE_NUL) && nact) begin
               if (crh) begin
                  res_v[n] = tls_pkg::make_rsp(tls_pkg::KIND_LINE, tls_pkg::BYTE_CR, '0,
                                               tls_pkg::ANOM_NONE);
                  n   = n + 2'd1;
                  crh = 1'b0;
               end
               res_v[n] = tls_pkg::make_rsp(tls_pkg::KIND_ANOM, 8'd0, '0,
                                            tls_pkg::ANOM_NUL);
               n    = n + 2'd1;
               nact = 1'b0;
            end else begin
               if (crh) begin
                  res_v[n] = tls_pkg::make_rsp(tls_pkg::KIND_LINE, tls_pkg::BYTE_CR, '0,
                                               tls_pkg::ANOM_NONE);
                  n   = n + 2'd1;
                  crh = 1'b0;
               end
               res_v[n] = tls_pkg::make_rsp(tls_pkg::KIND_LINE, b, '0,
                                            tls_pkg::ANOM_NONE);
               n        = n + 2'd1;
               if (len != tls_pkg::LINE_LEN_MAX) begin
                  len = len + LW'(1);
               end
            end

            // A CR that was not followed by LF is reported as a lone CR.
            if (!done) begin
               if (lwc) begin
                  res_v[n] = tls_pkg::make_rsp(tls_pkg::KIND_ANOM, 8'd0, '0,
                                               tls_pkg::ANOM_CR);
                  n        = n + 2'd1;
               end
               lwc = (b == tls_pkg::BYTE_CR);
            end
         end
      end

      // Mark the final beat of this item.
      if (n != 2'd0) begin
         res_v[n - 2'd1].last_of_run = 1'b1;
      end
      res_cnt = n;

      last_was_cr_in = last_was_cr_ff;
      cr_held_in     = cr_held_ff;
      nul_active_in  = nul_active_ff;
      line_len_in    = line_len_ff;
      plain_rem_in   = plain_rem_ff;
      skip_rem_in    = skip_rem_ff;
      skip_pend_in   = skip_pend_ff;
      if (req_accept) begin
         last_was_cr_in = lwc;
         cr_held_in     = crh;
         nul_active_in  = nact;
         line_len_in    = len;
         plain_rem_in   = plain;
         skip_rem_in    = skr;
         skip_pend_in   = pend;
      end

      // Register writes; the NUL report write also reloads NUL flagging.
      cr_is_eol_in  = cr_is_eol_ff;
      lf_is_eol_in  = lf_is_eol_ff;
      nul_report_in = nul_report_ff;
      if (csr_we) begin
         unique case (csr_index)
            tls_pkg::CSR_CR_IS_EOL: cr_is_eol_in = csr_wdata[0];
            tls_pkg::CSR_LF_IS_EOL: lf_is_eol_in = csr_wdata[0];
            tls_pkg::CSR_NUL_REPORT: begin
               nul_report_in = csr_wdata[0];
               nul_active_in = csr_wdata[0];
            end
            default: begin
               nul_report_in = nul_report_ff;
            end
         endcase
      end
   end

   // Result buffer: load a fresh item, else advance one beat per pop.
   always_comb begin
      slot_in  = slot_ff;
      count_in = count_ff;
      if (req_accept) begin
         slot_in  = res_v;
         count_in = res_cnt;
      end else if (rsp_pop) begin
         slot_in[0] = slot_ff[1];
         slot_in[1] = slot_ff[2];
         count_in   = count_ff - 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cr_is_eol_ff   <= 1'b1;
         lf_is_eol_ff   <= 1'b1;
         nul_report_ff  <= 1'b0;
         last_was_cr_ff <= 1'b0;
         cr_held_ff     <= 1'b0;
         nul_active_ff  <= 1'b0;
         line_len_ff    <= '0;
         plain_rem_ff   <= '0;
         skip_rem_ff    <= '0;
         skip_pend_ff   <= '0;
         count_ff       <= 2'd0;
      end else begin
         cr_is_eol_ff   <= cr_is_eol_in;
         lf_is_eol_ff   <= lf_is_eol_in;
         nul_report_ff  <= nul_report_in;
         last_was_cr_ff <= last_was_cr_in;
         cr_held_ff     <= cr_held_in;
         nul_active_ff  <= nul_active_in;
         line_len_ff    <= line_len_in;
         plain_rem_ff   <= plain_rem_in;
         skip_rem_ff    <= skip_rem_in;
         skip_pend_ff   <= skip_pend_in;
         count_ff       <= count_in;
      end
   end

   // Payload slots hold data only; no reset needed.
   always_ff @(posedge clock) begin
      slot_ff <= slot_in;
   end

   // A held CR is always the byte just before.
   `TLS_ASSERT_NOW(a_held_cr_is_last, clock, reset, cr_held_ff, last_was_cr_ff)
   // A new beat is taken only when the buffer is empty or emptying.
   `TLS_ASSERT_NOW(a_accept_on_empty, clock, reset, req_accept,
                   (count_ff == 2'd0) || ((count_ff == 2'd1) && !rsp_stall))
   // The last buffered beat closes its item.
   `TLS_ASSERT_NOW(a_last_beat_marked, clock, reset, rsp_valid && (count_ff == 2'd1),
                   rsp_payload.last_of_run)

endmodule

`default_nettype wire

// File: test/tb_text_line_splitter_unit.sv
`timescale 1ns / 1ps
// Testbench for text_line_splitter_unit: directed line-ending, held-CR, NUL and count tests,
// then random byte streams; every result beat is checked against a local framing model.
// Depends on tls_pkg and the splitter RTL only.

module tb_text_line_splitter_unit;

   localparam int CYCLE_LIMIT  = 2_000_000;
   localparam int DRAIN_CYCLES = 4;
   localparam int CHUNK_ITEMS  = 28;

   // DUT ports; all inputs driven to known values from time zero
   logic                  clock       = 1'b0;
   logic                  reset       = 1'b1;
   logic                  req_valid   = 1'b0;
   logic                  req_stall;
   tls_pkg::req_beat_type req_payload = '0;
   logic                  rsp_valid;
   logic                  rsp_stall   = 1'b0;
   tls_pkg::rsp_beat_type rsp_payload;
   logic                  csr_we      = 1'b0;
   logic [1:0]            csr_index   = '0;
   logic [0:0]            csr_wdata   = '0;

   // framing model: register copies and stream state, at reset values
   logic                               cr_ends_line  = 1'b1;
   logic                               lf_ends_line  = 1'b1;
   logic                               nul_watch     = 1'b0;
   logic                               prev_cr       = 1'b0;
   logic                               cr_waiting    = 1'b0;
   logic [tls_pkg::LINE_LEN_WIDTH-1:0] line_count    = '0;
   logic [tls_pkg::COUNT_WIDTH-1:0]    plain_left    = '0;
   logic [tls_pkg::COUNT_WIDTH-1:0]    skip_left     = '0;
   logic [tls_pkg::COUNT_WIDTH-1:0]    skip_deferred = '0;

   tls_pkg::rsp_beat_type item_results[$];     // beats caused by the item being framed
   tls_pkg::rsp_beat_type pending_results[$];  // beats still owed by the DUT, oldest first
   tls_pkg::rsp_beat_type got_want;

   int errors    = 0;
   int cycles    = 0;
   int idle_pct  = 0;
   int stall_pct = 0;

   text_line_splitter_unit dut (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_payload (req_payload),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_payload (rsp_payload),
      .csr_we      (csr_we),
      .csr_index   (csr_index),
      .csr_wdata   (csr_wdata)
   );

   always #1 clock = ~clock;

   // ------------------------------------------------------------------
   // Framing model
   // ------------------------------------------------------------------

   task automatic emit(input logic [2:0] k, input logic [7:0] val,
                       input logic [15:0] len, input logic [1:0] code);
      tls_pkg::rsp_beat_type r;
      r.kind         = k;
      r.out_byte     = val;
      r.line_length  = len;
      r.anomaly_code = code;
      r.last_of_run  = 1'b0;
      item_results.push_back(r);
   endtask

   // A CR kept in the line goes out ahead of whatever comes next.
   task automatic flush_held_cr();
      if (cr_waiting) begin
         emit(tls_pkg::KIND_LINE, tls_pkg::BYTE_CR, '0, tls_pkg::ANOM_NONE);
         cr_waiting = 1'b0;
      end
   endtask

   task automatic close_line();
      emit(tls_pkg::KIND_EOL, 8'd0, line_count, tls_pkg::ANOM_NONE);
      line_count = '0;
   endtask

   // Count one stored byte; hold at the maximum once saturated.
   task automatic count_byte();
      if (line_count != tls_pkg::LINE_LEN_MAX) line_count = line_count + 1'b1;
   endtask

   task automatic frame_data_byte(input logic [7:0] b);
      logic crlf_eaten;
      crlf_eaten = 1'b0;
      // LF right after a terminating CR: absorb it, but only after any held CR goes out
      if (cr_ends_line && prev_cr && b == tls_pkg::BYTE_LF) begin
         flush_held_cr();
         prev_cr    = 1'b0;
         crlf_eaten = 1'b1;
      end
      // plain bytes bypass framing entirely
      if (plain_left != 0) begin
         if (!crlf_eaten) begin
            flush_held_cr();
            emit(tls_pkg::KIND_PLAIN, b, '0, tls_pkg::ANOM_NONE);
            plain_left = plain_left - 1'b1;
            prev_cr    = 1'b0;
         end
         return;
      end
      // a deferred skip arms here, after the CRLF check
      if (skip_deferred != 0) begin
         skip_left     = skip_deferred;
         skip_deferred = '0;
      end
      if (crlf_eaten) return;
      // skipped bytes leave the CR tracking untouched
      if (skip_left != 0) begin
         emit(tls_pkg::KIND_SKIP, b, '0, tls_pkg::ANOM_NONE);
         skip_left = skip_left - 1'b1;
         return;
      end

      if (b == tls_pkg::BYTE_CR) begin
         flush_held_cr();
         if (cr_ends_line) begin
            close_line();
            prev_cr = 1'b1;
            return;
         end
         count_byte();
         cr_waiting = 1'b1;
      end else if (b == tls_pkg::BYTE_LF) begin
         if (prev_cr) begin
            // drop the held CR from the count unless the count has saturated
            if (cr_waiting) begin
               if (line_count != 0 && line_count != tls_pkg::LINE_LEN_MAX)
                  line_count = line_count - 1'b1;
               cr_waiting = 1'b0;
            end
            close_line();
            prev_cr = 1'b0;
            return;
         end
         if (lf_ends_line) begin
            close_line();
            prev_cr = 1'b0;
            return;
         end
         emit(tls_pkg::KIND_ANOM, 8'd0, '0, tls_pkg::ANOM_LF);
         emit(tls_pkg::KIND_LINE, b, '0, tls_pkg::ANOM_NONE);
         count_byte();
      end else if (b == tls_pkg::BYTE_NUL && nul_watch) begin
         // first NUL is reported and dropped, then flagging turns off
         flush_held_cr();
         emit(tls_pkg::KIND_ANOM, 8'd0, '0, tls_pkg::ANOM_NUL);
         nul_watch = 1'b0;
      end else begin
         flush_held_cr();
         emit(tls_pkg::KIND_LINE, b, '0, tls_pkg::ANOM_NONE);
         count_byte();
      end

      // a CR not followed by LF is a lone CR
      if (prev_cr) emit(tls_pkg::KIND_ANOM, 8'd0, '0, tls_pkg::ANOM_CR);
      prev_cr = (b == tls_pkg::BYTE_CR);
   endtask

   // Work out the beats one accepted item causes and queue them.
   task automatic frame_item(input tls_pkg::req_beat_type b);
      tls_pkg::rsp_beat_type r;
      item_results.delete();
      case (b.mode)
         tls_pkg::MODE_DATA: frame_data_byte(b.data_byte);
         tls_pkg::MODE_PLAIN: plain_left = b.length_value;
         tls_pkg::MODE_SKIP: begin
            if (prev_cr) begin
               skip_deferred = b.length_value;
            end else begin
               skip_deferred = '0;
               skip_left     = b.length_value;
            end
         end
         default: begin
            // end of stream closes a partial line like an LF would
            if (line_count != 0) frame_data_byte(tls_pkg::BYTE_LF);
         end
      endcase
      if (item_results.size() != 0) begin
         r = item_results.pop_back();
         r.last_of_run = 1'b1;
         item_results.push_back(r);
      end
      foreach (item_results[i]) pending_results.push_back(item_results[i]);
   endtask

   // ------------------------------------------------------------------
   // Drivers
   // ------------------------------------------------------------------

   // Send one beat: idle at random, then hold valid and payload until accepted.
   // Valid stays high into the next call, which lowers it only if it idles.
   task automatic send_beat(input logic [1:0] m, input logic [7:0] val,
                            input logic [31:0] len);
      tls_pkg::req_beat_type b;
      b.mode         = m;
      b.data_byte    = val;
      b.length_value = len;
      @(negedge clock);
      while ($urandom_range(99) < idle_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_payload <= b;
      req_valid   <= 1'b1;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      frame_item(b);
   endtask

   task automatic send_data(input logic [7:0] val);
      send_beat(tls_pkg::MODE_DATA, val, $urandom());
   endtask

   task automatic send_cmd(input logic [1:0] m, input logic [31:0] len);
      send_beat(m, 8'($urandom_range(255)), len);
   endtask

   // Drop valid, wait until every owed beat has arrived, then give the
   // block time to finish items that cause no beat.
   task automatic settle();
      int n;
      @(negedge clock);
      req_valid <= 1'b0;
      while (pending_results.size() != 0) @(posedge clock);
      for (n = 0; n < DRAIN_CYCLES; n++) @(posedge clock);
   endtask

   // Register write; only called while the block is idle.
   task automatic write_reg(input logic [1:0] idx, input logic val);
      @(negedge clock);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      @(posedge clock);
      case (idx)
         tls_pkg::CSR_CR_IS_EOL: cr_ends_line = val;
         tls_pkg::CSR_LF_IS_EOL: lf_ends_line = val;
         default: nul_watch = val;
      endcase
      @(negedge clock);
      csr_we <= 1'b0;
   endtask

   task automatic set_modes(input logic cr_eol, input logic lf_eol, input logic nuls);
      write_reg(tls_pkg::CSR_CR_IS_EOL, cr_eol);
      write_reg(tls_pkg::CSR_LF_IS_EOL, lf_eol);
      write_reg(tls_pkg::CSR_NUL_REPORT, nuls);
   endtask

   // ------------------------------------------------------------------
   // Tests
   // ------------------------------------------------------------------

   // Reset modes: CR and LF both end lines, CRLF counts once.
   task automatic test_line_endings();
      send_data("a");
      send_data(tls_pkg::BYTE_CR);
      send_data(tls_pkg::BYTE_LF);    // absorbed as the tail of CRLF
      send_data(tls_pkg::BYTE_LF);    // empty line
      send_data(tls_pkg::BYTE_CR);
      send_data("x");                 // lone CR reported
      send_cmd(tls_pkg::MODE_EOS, 32'd0);
      send_cmd(tls_pkg::MODE_EOS, 32'hFFFF_FFFF);  // empty line: no beat
      send_data(8'hFF);
      send_data(tls_pkg::BYTE_NUL);   // NUL is an ordinary byte with flagging off
   endtask

   // CR kept in the line: held back, then either dropped by LF or released.
   task automatic test_held_cr();
      settle();
      write_reg(tls_pkg::CSR_CR_IS_EOL, 1'b0);
      send_data(tls_pkg::BYTE_CR);
      send_data(tls_pkg::BYTE_LF);
      send_data("b");
      send_data(tls_pkg::BYTE_CR);
      send_data("c");
      settle();
      write_reg(tls_pkg::CSR_LF_IS_EOL, 1'b0);
      send_data(tls_pkg::BYTE_LF);    // lone LF stays in the line
      send_data(tls_pkg::BYTE_CR);
      send_data(tls_pkg::BYTE_LF);
   endtask

   // First NUL dropped and reported, the second passes as a line byte.
   task automatic test_nul_flag();
      settle();
      write_reg(tls_pkg::CSR_NUL_REPORT, 1'b1);
      send_data(tls_pkg::BYTE_NUL);
      send_data(tls_pkg::BYTE_NUL);
   endtask

   // Plain and skip counts, a skip deferred behind a CR, and full-width counts.
   task automatic test_counts();
      settle();
      write_reg(tls_pkg::CSR_CR_IS_EOL, 1'b1);
      write_reg(tls_pkg::CSR_LF_IS_EOL, 1'b1);
      send_cmd(tls_pkg::MODE_PLAIN, 32'd1);
      send_data(tls_pkg::BYTE_CR);    // passes as plain
      send_data(tls_pkg::BYTE_CR);    // ends the line
      send_cmd(tls_pkg::MODE_SKIP, 32'd2);
      send_data(tls_pkg::BYTE_LF);    // eaten, then the skip arms
      send_data("q");
      send_data("r");
      send_data("z");
      send_cmd(tls_pkg::MODE_PLAIN, 32'hFFFF_FFFF);
      send_cmd(tls_pkg::MODE_PLAIN, 32'd0);
      send_cmd(tls_pkg::MODE_SKIP, 32'hFFFF_FFFF);
      send_cmd(tls_pkg::MODE_SKIP, 32'd0);
      send_cmd(tls_pkg::MODE_EOS, 32'd0);
   endtask

   // Mostly stream bytes rich in CR, LF and NUL; commands keep small counts so
   // the stream stays framed, with a full-width count now and then replaced at once.
   task automatic random_item();
      int         pick;
      logic [1:0] m;
      logic [7:0] val;
      pick = $urandom_range(99);
      if (pick < 62) begin
         case ($urandom_range(9))
            0, 1, 2: val = tls_pkg::BYTE_CR;
            3, 4: val = tls_pkg::BYTE_LF;
            5: val = tls_pkg::BYTE_NUL;
            default: val = 8'($urandom_range(255));
         endcase
         send_data(val);
      end else if (pick < 72) begin
         send_cmd(tls_pkg::MODE_EOS, $urandom());
      end else begin
         m = (pick < 86) ? tls_pkg::MODE_PLAIN : tls_pkg::MODE_SKIP;
         if ($urandom_range(3) == 0) send_cmd(m, $urandom());
         send_cmd(m, $urandom_range(4));
      end
   endtask

   // Six chunks: modes all on, all off, then random; sender idles lightly while the
   // receiver stalls hard, then the reverse, then no idling or stalling at all.
   task automatic test_random_stream();
      int chunk;
      int n;
      for (chunk = 0; chunk < 6; chunk++) begin
         settle();
         idle_pct  = (chunk < 2) ? 6 : (chunk < 4) ? 77 : 0;
         stall_pct = (chunk < 2) ? 77 : (chunk < 4) ? 6 : 0;
         if (chunk == 0) set_modes(1'b1, 1'b1, 1'b1);
         else if (chunk == 1) set_modes(1'b0, 1'b0, 1'b0);
         else set_modes(1'($urandom_range(1)), 1'($urandom_range(1)),
                        1'($urandom_range(1)));
         for (n = 0; n < CHUNK_ITEMS; n++) random_item();
      end
   endtask

   // ------------------------------------------------------------------
   // Receiver, checker and watchdog
   // ------------------------------------------------------------------

   always @(negedge clock) rsp_stall <= ($urandom_range(99) < stall_pct);

   function automatic int field_bad(input string name, input logic [15:0] want_v,
                                    input logic [15:0] got_v);
      if (want_v !== got_v) begin
         $error("%s: expected %0d, actual %0d", name, want_v, got_v);
         return 1;
      end
      return 0;
   endfunction

   // Compare each accepted result beat with the oldest owed one.
   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_results.size() == 0) begin
            $error("result beat with nothing owed: kind %0d, byte %0d",
                   rsp_payload.kind, rsp_payload.out_byte);
            errors = errors + 1;
         end else begin
            got_want = pending_results.pop_front();
            errors = errors
               + field_bad("kind", 16'(got_want.kind), 16'(rsp_payload.kind))
               + field_bad("out_byte", 16'(got_want.out_byte),
                           16'(rsp_payload.out_byte))
               + field_bad("line_length", got_want.line_length, rsp_payload.line_length)
               + field_bad("anomaly_code", 16'(got_want.anomaly_code),
                           16'(rsp_payload.anomaly_code))
               + field_bad("last_of_run", 16'(got_want.last_of_run),
                           16'(rsp_payload.last_of_run));
         end
      end
   end

   always @(posedge clock) begin
      cycles = cycles + 1;
      if (cycles == CYCLE_LIMIT) begin
         $display("TB_ERROR");
         $finish;
      end
   end

   // ------------------------------------------------------------------
   // Sequence
   // ------------------------------------------------------------------

   initial begin
      repeat (12) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      idle_pct  = 6;
      stall_pct = 77;
      test_line_endings();
      test_held_cr();
      test_nul_flag();
      test_counts();
      test_random_stream();
      settle();
      if (errors == 0) begin
         $display("TB_OK");
      end else begin
         $display("TB_ERROR");
      end
      $finish;
   end

endmodule
